// ===== src/msp_pkg.sv =====
// Shared types and constants of the MSP request frame parser.
package msp_pkg;

   // Frame marker characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_EM     = 8'h4D;
   localparam logic [7:0] CHAR_LESS   = 8'h3C;

   // Payload store geometry: two banks of one frame each
   localparam int STORE_DEPTH     = 64;
   localparam int IDX_W           = $clog2(STORE_DEPTH);
   localparam int ADDR_W          = IDX_W + 1;
   localparam int MSP_MAX_PAYLOAD = 64;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DOLLAR = 3'd1,
      PH_EM     = 3'd2,
      PH_LESS   = 3'd3,
      PH_SIZED  = 3'd4,
      PH_DATA   = 3'd5,
      PH_CHECK  = 3'd6
   } msp_phase_type;

   // One validated frame waiting for the emitter
   typedef struct packed {
      logic [7:0] command;
      logic [6:0] size;
      logic       bank;
   } msp_desc_type;

   typedef struct packed {
      logic         push;
      msp_desc_type desc;
   } msp_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } msp_qstat_type;

   // Payload store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } msp_wr_type;

endpackage

// ===== src/msp_request_frame_parser.sv =====
// Top level of the MSP request frame parser: parser, frame queue and emitter.
//
//   channel   ports                               direction  accepted when
//   request   req_push, req_full, req_rx_byte     in         req_push && !req_full
//   result    rsp_pop, rsp_empty, rsp_command,    out        rsp_pop && !rsp_empty
//             rsp_payload_size, rsp_has_payload,
//             rsp_byte_index, rsp_payload_byte,
//             rsp_last
//
// One request byte is taken per cycle while req_full is low. A good frame is posted
// to the frame queue when its checksum byte is taken; the emitter then gives one result
// per cycle while results are popped, limited by the single read port of the payload store. Two payload banks let one
// frame be received while the previous one drains. The request side stalls
// (req_full) only in the data or checksum phase while both banks hold frames not
// yet fully read out of the store.
// Synchronous reset clears the parser phase, the frame queue and the output
// register; the payload store needs no clearing.
module msp_request_frame_parser #(
   parameter int MAX_PAYLOAD = msp_pkg::MSP_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_command,
   output logic [6:0] rsp_payload_size,
   output logic       rsp_has_payload,
   output logic [5:0] rsp_byte_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last
);
   import msp_pkg::*;

   msp_qstat_type q_stat;
   msp_push_type  q_push;
   msp_desc_type  q_head;
   msp_wr_type    wr;
   logic          q_pop;

   msp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .wr          (wr)
   );

   msp_frame_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_head (q_head),
      .q_stat (q_stat)
   );

   msp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .q_head           (q_head),
      .q_stat           (q_stat),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_command      (rsp_command),
      .rsp_payload_size (rsp_payload_size),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== src/msp_front.sv =====
// Byte parser: recognizes request frames, stores payload, posts good frames.
module msp_front #(
   parameter int MAX_PAYLOAD = msp_pkg::MSP_MAX_PAYLOAD
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_rx_byte,
   output logic                  req_full,
   input  msp_pkg::msp_qstat_type q_stat,
   output msp_pkg::msp_push_type  q_push,
   output msp_pkg::msp_wr_type    wr
);
   import msp_pkg::*;

   localparam int LIMIT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
   localparam logic [7:0] LIMIT_B = 8'(LIMIT);

   msp_phase_type phase_ff, phase_in;
   logic [6:0]    size_ff, size_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    check_ff, check_in;
   logic [6:0]    count_ff, count_in;
   logic          bank_ff, bank_in;
   logic          accept;
   logic [6:0]    count_next;

   // Stall only where a bank or a queue slot is needed and none is free
   assign req_full   = q_stat.full && (phase_ff == PH_DATA || phase_ff == PH_CHECK);
   assign accept     = req_push && !req_full;
   assign count_next = count_ff + 7'd1;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_DOLLAR: phase_in = (req_rx_byte == CHAR_EM) ? PH_EM : PH_IDLE;
            PH_EM:     phase_in = (req_rx_byte == CHAR_LESS) ? PH_LESS : PH_IDLE;
            PH_LESS:   phase_in = (req_rx_byte > LIMIT_B) ? PH_IDLE : PH_SIZED;
            PH_SIZED:  phase_in = (size_ff == 7'd0) ? PH_CHECK : PH_DATA;
            PH_DATA:   phase_in = (count_next >= size_ff) ? PH_CHECK : PH_DATA;
            PH_CHECK:  phase_in = PH_IDLE;
            default:   phase_in = (req_rx_byte == CHAR_DOLLAR) ? PH_DOLLAR : PH_IDLE;
         endcase
      end
   end

   // Frame fields, running checksum, store writes and frame posting
   always_comb begin
      size_in          = size_ff;
      cmd_in           = cmd_ff;
      check_in         = check_ff;
      count_in         = count_ff;
      bank_in          = bank_ff;
      wr.en            = 1'b0;
      wr.addr          = {bank_ff, count_ff[IDX_W-1:0]};
      wr.data          = req_rx_byte;
      q_push.push      = 1'b0;
      q_push.desc.command = cmd_ff;
      q_push.desc.size    = size_ff;
      q_push.desc.bank    = bank_ff;
      if (accept) begin
         case (phase_ff)
            PH_LESS: begin
               size_in  = req_rx_byte[6:0];
               check_in = req_rx_byte;
            end
            PH_SIZED: begin
               cmd_in   = req_rx_byte;
               check_in = check_ff ^ req_rx_byte;
               count_in = 7'd0;
            end
            PH_DATA: begin
               wr.en    = 1'b1;
               check_in = check_ff ^ req_rx_byte;
               count_in = count_next;
            end
            PH_CHECK: begin
               if (req_rx_byte == check_ff) begin
                  q_push.push = 1'b1;
                  bank_in     = ~bank_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bank_ff  <= bank_in;
      end
      size_ff  <= size_in;
      cmd_ff   <= cmd_in;
      check_ff <= check_in;
      count_ff <= count_in;
   end

endmodule

// ===== src/msp_frame_queue.sv =====
// Two-entry queue of validated frames between parser and emitter.
module msp_frame_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  msp_pkg::msp_push_type  q_push,
   input  logic                  q_pop,
   output msp_pkg::msp_desc_type  q_head,
   output msp_pkg::msp_qstat_type q_stat
);
   import msp_pkg::*;

   msp_desc_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign q_head       = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = q_push.push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, q_push.push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.desc;
      end
   end

endmodule

// ===== src/msp_back.sv =====
// Payload store and emitter: walks each queued frame into one result per byte, or one result if it has no payload.
module msp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  msp_pkg::msp_wr_type    wr,
   input  msp_pkg::msp_desc_type  q_head,
   input  msp_pkg::msp_qstat_type q_stat,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_command,
   output logic [6:0]            rsp_payload_size,
   output logic                  rsp_has_payload,
   output logic [5:0]            rsp_byte_index,
   output logic [7:0]            rsp_payload_byte,
   output logic                  rsp_last
);
   import msp_pkg::*;

   logic [7:0] mem [2*STORE_DEPTH];

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       cmd_ff;
   logic [6:0]       size_ff;
   logic             has_ff;
   logic [5:0]       index_ff;
   logic             last_ff;
   logic [7:0]       rd_data_ff;
   logic             load;
   logic             take;
   logic             is_last;

   // Refill the output register when it is free or being drained
   assign load    = !valid_ff || rsp_pop;
   assign take    = load && !q_stat.empty;
   assign is_last = (q_head.size == 7'd0) || ({1'b0, idx_ff} + 7'd1 == q_head.size);
   assign q_pop   = take && is_last;

   always_comb begin
      valid_in = load ? take : valid_ff;
      idx_in   = idx_ff;
      if (take) begin
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   // Store payload and read the next byte into the output register
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (take) begin
         rd_data_ff <= mem[{q_head.bank, idx_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (take) begin
         cmd_ff   <= q_head.command;
         size_ff  <= q_head.size;
         has_ff   <= (q_head.size != 7'd0);
         index_ff <= 6'(idx_ff);
         last_ff  <= is_last;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_command      = cmd_ff;
   assign rsp_payload_size = size_ff;
   assign rsp_has_payload  = has_ff;
   assign rsp_byte_index   = has_ff ? index_ff : 6'd0;
   assign rsp_payload_byte = has_ff ? rd_data_ff : 8'd0;
   assign rsp_last         = last_ff;

endmodule
